FILE: src/ame_pkg.sv
// Shared types and constants for the accelerometer magnitude smoother.
package ame_pkg;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } in_t;

  typedef struct packed {
    logic [15:0] raw_magnitude;
    logic [31:0] smoothed_magnitude;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT_GO,
    ST_ROOT,
    ST_SCALE,
    ST_UPDATE
  } state_e;

  localparam logic [16:0] ALPHA_ONE   = 17'd65536;
  localparam logic [16:0] ALPHA_RESET = 17'd26214;

  localparam int unsigned SQ_DIGITS  = 4;
  localparam int unsigned AL_DIGITS  = 5;
  localparam int unsigned ROOT_STEPS = 16;

endpackage

FILE: src/accel_magnitude_ema_top.sv
// Top level of the accelerometer magnitude smoother.
// Takes one three-axis sample per word, returns its floor Euclidean magnitude and the
// exponentially smoothed magnitude in unsigned Q16.16. A sample occupies the block from
// acceptance until its commit: digit-serial squaring, the two-bit-per-cycle square root
// unit, which sets the rate, digit-serial alpha scaling (skipped for the first sample after
// reset, which seeds the average) and a commit step that waits while the output is stalled.
// The finished word waits in an output register so the next sample is taken meanwhile.
module accel_magnitude_ema_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  ame_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output ame_pkg::out_t  out_data_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [16:0]    cfg_data_i
);

  ame_pkg::state_e state_q, state_d;
  logic [2:0]      cnt_q, cnt_d;
  logic [16:0]     alpha_q;
  logic [31:0]     avg_q;
  logic            seeded_q;
  logic            out_valid_q, out_valid_d;
  ame_pkg::out_t   out_q;

  logic        accept, sq_step, root_start, sc_step, commit, out_free, cnt_last;
  logic        rt_done;
  logic [15:0] rt_root;

  logic [15:0] mx_q, my_q, mz_q;
  logic [15:0] dx_q, dy_q, dz_q;
  logic [31:0] acc_q;
  logic [15:0] mag_q;
  logic signed [32:0] diff_q;
  logic [19:0] al_q;
  logic signed [37:0] hi_q;
  logic [19:0] lo_q;

  logic [19:0] px, py, pz;
  logic [21:0] part;
  logic [16:0] a_eff;
  logic signed [32:0] diff_d;
  logic signed [4:0]  dig_s;
  logic signed [37:0] prod, t;
  logic [31:0] delta, avg_new;
  logic [15:0] abs_x, abs_y, abs_z;

  // Control
  assign out_free = !out_valid_q || !out_stall_i;
  assign cnt_last = (state_q == ame_pkg::ST_SQUARE) ? (cnt_q == 3'(ame_pkg::SQ_DIGITS - 1))
                                                    : (cnt_q == 3'(ame_pkg::AL_DIGITS - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ame_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = ame_pkg::ST_SQUARE;
      end
      ame_pkg::ST_SQUARE: begin
        if (cnt_last) state_d = ame_pkg::ST_ROOT_GO;
      end
      ame_pkg::ST_ROOT_GO: begin
        state_d = ame_pkg::ST_ROOT;
      end
      ame_pkg::ST_ROOT: begin
        if (rt_done) state_d = seeded_q ? ame_pkg::ST_SCALE : ame_pkg::ST_UPDATE;
      end
      ame_pkg::ST_SCALE: begin
        if (cnt_last) state_d = ame_pkg::ST_UPDATE;
      end
      ame_pkg::ST_UPDATE: begin
        if (out_free) state_d = ame_pkg::ST_IDLE;
      end
      default: begin
        state_d = ame_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    sq_step    = 1'b0;
    root_start = 1'b0;
    sc_step    = 1'b0;
    commit     = 1'b0;
    case (state_q)
      ame_pkg::ST_IDLE:    in_stall_o = 1'b0;
      ame_pkg::ST_SQUARE:  sq_step    = 1'b1;
      ame_pkg::ST_ROOT_GO: root_start = 1'b1;
      ame_pkg::ST_SCALE:   sc_step    = 1'b1;
      ame_pkg::ST_UPDATE:  commit     = out_free;
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_d = commit || (out_valid_q && out_stall_i);

  always_comb begin
    cnt_d = cnt_q;
    if (sq_step || sc_step) begin
      cnt_d = cnt_last ? 3'd0 : cnt_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ame_pkg::ST_IDLE;
      cnt_q       <= '0;
      alpha_q     <= ame_pkg::ALPHA_RESET;
      avg_q       <= '0;
      seeded_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) alpha_q <= cfg_data_i;
      if (commit) begin
        avg_q    <= avg_new;
        seeded_q <= 1'b1;
      end
    end
  end

  assign cfg_ready_o = 1'b1;

  // Datapath
  assign abs_x = in_data_i.accel_x[15] ? 16'(-in_data_i.accel_x) : in_data_i.accel_x;
  assign abs_y = in_data_i.accel_y[15] ? 16'(-in_data_i.accel_y) : in_data_i.accel_y;
  assign abs_z = in_data_i.accel_z[15] ? 16'(-in_data_i.accel_z) : in_data_i.accel_z;

  assign px   = 20'(mx_q) * 20'(dx_q[15:12]);
  assign py   = 20'(my_q) * 20'(dy_q[15:12]);
  assign pz   = 20'(mz_q) * 20'(dz_q[15:12]);
  assign part = 22'(px) + 22'(py) + 22'(pz);

  assign a_eff  = (alpha_q > ame_pkg::ALPHA_ONE) ? ame_pkg::ALPHA_ONE : alpha_q;
  assign diff_d = $signed({1'b0, rt_root, 16'h0000}) - $signed({1'b0, avg_q});

  assign dig_s = $signed({1'b0, al_q[3:0]});
  assign prod  = 38'(diff_q) * 38'(dig_s);
  assign t     = hi_q + prod;

  assign delta   = {hi_q[27:0], lo_q[19:16]};
  assign avg_new = seeded_q ? avg_q + delta : {mag_q, 16'h0000};

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mx_q  <= abs_x;
      my_q  <= abs_y;
      mz_q  <= abs_z;
      dx_q  <= abs_x;
      dy_q  <= abs_y;
      dz_q  <= abs_z;
      acc_q <= '0;
    end else if (sq_step) begin
      dx_q  <= {dx_q[11:0], 4'h0};
      dy_q  <= {dy_q[11:0], 4'h0};
      dz_q  <= {dz_q[11:0], 4'h0};
      acc_q <= {acc_q[27:0], 4'h0} + 32'(part);
    end
    if (state_q == ame_pkg::ST_ROOT && rt_done) begin
      mag_q  <= rt_root;
      diff_q <= diff_d;
      al_q   <= {3'b000, a_eff};
      hi_q   <= '0;
      lo_q   <= '0;
    end else if (sc_step) begin
      al_q <= {4'h0, al_q[19:4]};
      hi_q <= t >>> 4;
      lo_q <= {t[3:0], lo_q[19:4]};
    end
    if (commit) begin
      out_q.raw_magnitude      <= mag_q;
      out_q.smoothed_magnitude <= avg_new;
    end
  end

  ame_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_start),
    .value_i (acc_q),
    .done_o  (rt_done),
    .root_o  (rt_root)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  a_word_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ame_pkg::ST_UPDATE))
    else $error("output word without commit");

  a_seed_after_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> seeded_q)
    else $error("average not seeded after commit");

  a_scale_needs_seed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ame_pkg::ST_SCALE |-> seeded_q)
    else $error("scaling before the average is seeded");

  a_root_done_in_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rt_done |-> state_q == ame_pkg::ST_ROOT)
    else $error("square root finished outside root state");

  a_held_word_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(out_q))
    else $error("stalled output word lost");

endmodule

FILE: src/ame_isqrt.sv
// Two-bit-per-cycle restoring integer square root of a 32-bit value.
module ame_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] value_i,
  output logic        done_o,
  output logic [15:0] root_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [31:0] rad_q;
  logic [16:0] rem_q;
  logic [15:0] root_q;
  logic [18:0] cur;
  logic [19:0] trial;
  logic        take;

  assign cur   = {rem_q, rad_q[31:30]};
  assign trial = {1'b0, cur} - {2'b00, root_q, 2'b01};
  assign take  = !trial[19];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + 4'd1;
      if (cnt_q == 4'(ame_pkg::ROOT_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= value_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[29:0], 2'b00};
      rem_q  <= take ? trial[16:0] : cur[16:0];
      root_q <= {root_q[14:0], take};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

FILE: sim/ame_checker.sv
`timescale 1ns / 1ps
// Checker that predicts the magnitude smoother's output words and compares them.
module ame_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_stall_i,
  input  ame_pkg::in_t   in_data_i,
  input  logic           out_valid_i,
  input  logic           out_stall_i,
  input  ame_pkg::out_t  out_data_i,
  input  logic           cfg_valid_i,
  input  logic           cfg_ready_i,
  input  logic [16:0]    cfg_data_i,
  output int             fail_count_o,
  output int             pending_o
);

  logic [16:0]   alpha_q;
  logic [31:0]   average_q;
  logic          seeded_q;
  ame_pkg::out_t magnitudes_q[$];

  function automatic logic [15:0] floor_root(logic [31:0] n);
    logic [31:0] rem;
    logic [31:0] root;
    logic [31:0] probe;
    rem   = n;
    root  = '0;
    probe = 32'h4000_0000;
    while (probe > rem) probe >>= 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    return root[15:0];
  endfunction

  function automatic ame_pkg::out_t smooth_sample(ame_pkg::in_t s);
    longint        x;
    longint        y;
    longint        z;
    longint        diff;
    longint        delta;
    logic [31:0]   target;
    logic [16:0]   weight;
    ame_pkg::out_t w;
    x = s.accel_x;
    y = s.accel_y;
    z = s.accel_z;
    w.raw_magnitude = floor_root(32'(x * x + y * y + z * z));
    target = {w.raw_magnitude, 16'h0000};
    if (!seeded_q) begin
      average_q = target;
      seeded_q  = 1'b1;
    end else begin
      weight    = (alpha_q > ame_pkg::ALPHA_ONE) ? ame_pkg::ALPHA_ONE : alpha_q;
      diff      = longint'(target) - longint'(average_q);
      delta     = (longint'(weight) * diff) >>> 16;
      average_q = 32'(longint'(average_q) + delta);
    end
    w.smoothed_magnitude = average_q;
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    ame_pkg::out_t want;
    if (!rst_ni) begin
      alpha_q      = ame_pkg::ALPHA_RESET;
      average_q    = '0;
      seeded_q     = 1'b0;
      magnitudes_q.delete();
      fail_count_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (magnitudes_q.size() == 0) begin
          $error("output word with no sample pending");
          fail_count_o++;
        end else begin
          want = magnitudes_q.pop_front();
          if (out_data_i.raw_magnitude !== want.raw_magnitude) begin
            $error("raw_magnitude: expected %0d, got %0d",
                   want.raw_magnitude, out_data_i.raw_magnitude);
            fail_count_o++;
          end
          if (out_data_i.smoothed_magnitude !== want.smoothed_magnitude) begin
            $error("smoothed_magnitude: expected %0d, got %0d",
                   want.smoothed_magnitude, out_data_i.smoothed_magnitude);
            fail_count_o++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) alpha_q = cfg_data_i;
      if (in_valid_i && !in_stall_i) magnitudes_q.push_back(smooth_sample(in_data_i));
    end
    pending_o = magnitudes_q.size();
  end

endmodule

FILE: sim/accel_magnitude_ema_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for the magnitude smoother: clock, reset, stimulus and verdict.
module accel_magnitude_ema_top_tb;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_stall;
  ame_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_stall;
  ame_pkg::out_t out_data;
  logic          cfg_valid;
  logic          cfg_ready;
  logic [16:0]   cfg_data;
  int            fail_count;
  int            pending;
  bit            steady;

  accel_magnitude_ema_top uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  ame_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < 21);
  end

  task automatic send_sample(logic signed [15:0] x, logic signed [15:0] y,
                             logic signed [15:0] z);
    while (!steady && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{accel_x: x, accel_y: y, accel_z: z};
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic write_alpha(logic [16:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [15:0] random_axis();
    case ($urandom_range(9))
      0:       return -16'sd32768;
      1:       return 16'sd32767;
      2, 3:    return 16'($urandom_range(200)) - 16'sd100;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [16:0] alpha;
    rst_n     = 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    steady    = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    send_sample(3, 4, 0);
    send_sample(0, 0, 0);
    send_sample(32767, 32767, 32767);
    send_sample(-32768, -32768, -32768);
    send_sample(-32768, 32767, 0);
    send_sample(0, 0, -32768);
    send_sample(1, 0, 0);
    send_sample(-1, -1, -1);
    send_sample(0, 0, 0);
    send_sample(12, -5, 84);

    write_alpha(17'd1);
    send_sample(-32768, -32768, -32768);
    send_sample(0, 0, 0);
    write_alpha(17'd0);
    send_sample(32767, 0, 0);
    send_sample(0, 0, 0);
    write_alpha(17'h1FFFF);
    send_sample(100, 200, -300);
    send_sample(0, -1, 0);
    write_alpha(17'd65537);
    send_sample(-32768, -32768, -32768);
    write_alpha(ame_pkg::ALPHA_ONE);
    send_sample(7, 7, 7);
    send_sample(0, 0, 0);

    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0:       alpha = ame_pkg::ALPHA_RESET;
        1:       alpha = 17'd1;
        2:       alpha = ame_pkg::ALPHA_ONE;
        3:       alpha = 17'($urandom);
        default: alpha = 17'($urandom_range(65536, 1));
      endcase
      write_alpha(alpha);
      steady = (phase == 4 || phase == 5);
      for (int i = 0; i < 55; i++) send_sample(random_axis(), random_axis(), random_axis());
    end
    steady = 1'b0;

    drain();
    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: accel_magnitude_ema_top.f
src/ame_pkg.sv
src/ame_isqrt.sv
src/accel_magnitude_ema_top.sv
sim/ame_checker.sv
sim/accel_magnitude_ema_top_tb.sv
